>>> src/mcfir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcfir_pkg
// Shared constants, operation codes and types of the multichannel FIR block.
// ----------------------------------------------------------------------------
package mcfir_pkg;

  localparam int MAX_TAPS     = 256;
  localparam int MAX_CHANNELS = 8;
  localparam int TAP_W        = $clog2(MAX_TAPS);
  localparam int CH_W         = 3;
  localparam int ADDR_W       = CH_W + TAP_W;
  localparam int STORE_DEPTH  = MAX_CHANNELS * MAX_TAPS;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = PROD_W + TAP_W + 1;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;

  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_LOAD_TAP = 2'd1;
  localparam logic [1:0] OP_LOAD_GAIN = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_TAPS_LEN      = 2'd1;
  localparam logic [1:0] REG_PREAMP_GAIN   = 2'd2;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] data;
    logic [CH_W-1:0]            load_channel;
    logic [7:0]                 tap_index;
    logic [GAIN_W-1:0]          gain;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_status_t;

endpackage
`default_nettype wire

>>> src/mcfir_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcfir_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcfir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/mcfir_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcfir_front
// Input side: takes items, drops unknown operations, queues the rest.
// ----------------------------------------------------------------------------
module mcfir_front
  import mcfir_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire item_t        in_item,
  input  wire back_status_t status,
  output logic              q_valid,
  output item_t             q_item,
  input  wire logic         q_pop
);

  item_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       accept;
  logic       enq;

  assign full    = (count == 2'd2) || status.clearing;
  assign accept  = push && !full;
  assign enq     = accept && (in_item.op != OP_NONE);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (enq) begin
        wptr <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(enq) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wptr] <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> src/mcfir_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcfir_back
// Execution side: history clear, loads, tap-by-tap MAC, gain scaling,
// saturation and the result register.
// ----------------------------------------------------------------------------
module mcfir_back
  import mcfir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [3:0]           channel_count,
  input  wire logic [8:0]           taps_len,
  input  wire logic [GAIN_W-1:0]    preamp_gain,
  input  wire logic                 q_valid,
  input  wire item_t                q_item,
  output logic                      q_pop,
  output back_status_t              status,
  output logic                      res_valid,
  input  wire logic                 res_pop,
  output logic [CH_W-1:0]           res_channel,
  output logic signed [SAMPLE_W-1:0] res_filtered,
  output logic                      res_saturated,
  output logic                      res_frame_end
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_MAC   = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_ROUND = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic [CH_W-1:0]   ch_pos;
  logic [TAP_W-1:0]  hist_pos;
  logic [GAIN_W-1:0] gains [MAX_CHANNELS];

  logic [CH_W-1:0]            ch;
  logic                       last;
  logic [8:0]                 t;
  logic [TAP_W-1:0]           hp;
  logic signed [SAMPLE_W-1:0] s;
  logic [8:0]                 k;
  logic [TAP_W-1:0]           idx;

  logic                       rd_v;
  logic                       prod_v;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [32:0]         v;
  logic signed [49:0]         p1;
  logic signed [54:0]         p2;

  logic [4:0]        cnt_eff;
  logic [8:0]        t_eff;
  logic [CH_W-1:0]   ch_use;
  logic [TAP_W-1:0]  hp_use;
  logic [8:0]        hp_plus;
  logic [TAP_W-1:0]  first_idx;
  logic [8:0]        idx_plus;
  logic [TAP_W-1:0]  idx_next;

  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [49:0]      p1_rnd;
  logic signed [54:0]      p2_rnd;
  logic                    sat_hi;
  logic                    sat_lo;

  logic              hist_we;
  logic [ADDR_W-1:0] hist_waddr;
  logic [SAMPLE_W-1:0] hist_wdata;
  logic [SAMPLE_W-1:0] hist_rdata;
  logic              tap_we;
  logic [SAMPLE_W-1:0] tap_rdata;
  logic              take;
  logic              out_free;

  always_comb begin
    if (channel_count == 4'd0) begin
      cnt_eff = 5'd1;
    end else if (5'(channel_count) > 5'(MAX_CHANNELS)) begin
      cnt_eff = 5'(MAX_CHANNELS);
    end else begin
      cnt_eff = 5'(channel_count);
    end
    t_eff   = (taps_len > 9'(MAX_TAPS)) ? 9'(MAX_TAPS) : taps_len;
    ch_use  = (5'(ch_pos) >= cnt_eff) ? '0 : ch_pos;
    hp_use  = (9'(hist_pos) >= t_eff) ? '0 : hist_pos;
    hp_plus = 9'(hp_use) + 9'd1;
    first_idx = (hp_plus >= t_eff) ? '0 : hp_plus[TAP_W-1:0];
    idx_plus  = 9'(idx) + 9'd1;
    idx_next  = (idx_plus >= t) ? '0 : idx_plus[TAP_W-1:0];
  end

  // Rounding adds half and floors.
  assign acc_rnd = (acc + $signed(ACC_W'(1) << 22)) >>> 23;
  assign p1_rnd  = (p1 + 50'sd2048) >>> 12;
  assign p2_rnd  = (p2 + 55'sd2048) >>> 12;
  assign sat_hi  = (p2_rnd > 55'sd8388607);
  assign sat_lo  = (p2_rnd < -55'sd8388608);

  assign take     = (state == S_IDLE) && q_valid;
  assign q_pop    = take;
  assign out_free = !res_valid || res_pop;

  assign status.clearing = (state == S_CLEAR);
  assign status.busy     = (state != S_IDLE);

  assign hist_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign hist_waddr = (state == S_CLEAR) ? clr_addr : {ch, hp};
  assign hist_wdata = (state == S_CLEAR) ? '0 : s;
  assign tap_we     = take && (q_item.op == OP_LOAD_TAP)
                      && (9'(q_item.tap_index) < 9'(MAX_TAPS))
                      && (5'(q_item.load_channel) < 5'(MAX_CHANNELS));

  mcfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr ({ch, idx}),
    .rdata (hist_rdata)
  );

  mcfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_taps (
    .clk   (clk),
    .we    (tap_we),
    .waddr ({q_item.load_channel, q_item.tap_index[TAP_W-1:0]}),
    .wdata (q_item.data),
    .raddr ({ch, k[TAP_W-1:0]}),
    .rdata (tap_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      ch_pos    <= '0;
      hist_pos  <= '0;
      res_valid <= 1'b0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        gains[i] <= UNITY_GAIN;
      end
    end else begin
      rd_v   <= (state == S_MAC);
      prod_v <= rd_v;
      if ((state == S_OUT) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take && (q_item.op == OP_LOAD_GAIN)
              && (5'(q_item.load_channel) < 5'(MAX_CHANNELS))) begin
            gains[q_item.load_channel] <= q_item.gain;
          end
          if (take && (q_item.op == OP_SAMPLE)) begin
            state <= (t_eff == 9'd0) ? S_MUL1 : S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_MAC;
        end
        S_MAC: begin
          if (k + 9'd1 == t) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !prod_v) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          state <= S_MUL1;
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state     <= S_IDLE;
            if (last) begin
              ch_pos <= '0;
              if (t != 9'd0) begin
                hist_pos <= (9'(hp) + 9'd1 >= t) ? '0 : hp + 1'b1;
              end
            end else begin
              ch_pos <= ch + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (take && (q_item.op == OP_SAMPLE)) begin
      ch   <= ch_use;
      last <= (5'(ch_use) + 5'd1 == cnt_eff);
      t    <= t_eff;
      hp   <= hp_use;
      s    <= q_item.data;
      k    <= '0;
      idx  <= first_idx;
      acc  <= '0;
      v    <= 33'(q_item.data);
    end else begin
      if (state == S_MAC) begin
        k   <= k + 9'd1;
        idx <= idx_next;
      end
      if (prod_v) begin
        acc <= acc + ACC_W'(prod);
      end
      if (state == S_ROUND) begin
        v <= acc_rnd[32:0];
      end
    end
    if (rd_v) begin
      prod <= $signed(tap_rdata) * $signed(hist_rdata);
    end
    if (state == S_MUL1) begin
      p1 <= v * $signed({1'b0, preamp_gain});
    end
    if (state == S_MUL2) begin
      p2 <= $signed(p1_rnd[37:0]) * $signed({1'b0, gains[ch]});
    end
    if ((state == S_OUT) && out_free) begin
      res_channel   <= ch;
      res_frame_end <= last;
      res_saturated <= sat_hi || sat_lo;
      if (sat_hi) begin
        res_filtered <= 24'sd8388607;
      end else if (sat_lo) begin
        res_filtered <= -24'sd8388608;
      end else begin
        res_filtered <= p2_rnd[SAMPLE_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> src/multichannel_fir_with_gain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_fir_with_gain
// Interleaved multichannel FIR with preamp and per-channel gain.
// ----------------------------------------------------------------------------
//  Port group  Direction  Handshake             Content
//  input       in         push / full           operation, sample, loads
//  result      out        empty / pop           channel, filtered, flags
//  config      in         psel/penable/pready   channel_count, taps_len, gain
//
// A sample with T taps in use runs one multiply-accumulate per tap, bound
// by the single read port of the history and tap memories, plus the
// history write, a drain, rounding and two gain multiplies.
// A gain-only sample skips to the gain multiplies; a load is taken at idle.
// After reset a clearing pass zeroes all 2048 history words;
// full stays high meanwhile.
// A result that is not popped holds the execution side in its output step;
// the two-entry queue in front then fills and full rises.
// ----------------------------------------------------------------------------
module multichannel_fir_with_gain
  import mcfir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            operation,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [CH_W-1:0]       load_channel,
  input  wire logic [7:0]            tap_index,
  input  wire logic signed [SAMPLE_W-1:0] coefficient,
  input  wire logic [GAIN_W-1:0]     gain,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [CH_W-1:0]            channel,
  output logic signed [SAMPLE_W-1:0] filtered,
  output logic                       saturated,
  output logic                       frame_end,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [3:0]        channel_count;
  logic [8:0]        taps_len;
  logic [GAIN_W-1:0] preamp_gain;
  item_t             in_item;
  item_t             q_item;
  logic              q_valid;
  logic              q_pop;
  back_status_t      status;
  logic              res_valid;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign empty  = !res_valid;

  assign in_item.op           = operation;
  assign in_item.data         = (operation == OP_SAMPLE) ? sample : coefficient;
  assign in_item.load_channel = load_channel;
  assign in_item.tap_index    = tap_index;
  assign in_item.gain         = gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 4'd2;
      taps_len      <= 9'd0;
      preamp_gain   <= UNITY_GAIN;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CHANNEL_COUNT: channel_count <= pwdata[3:0];
        REG_TAPS_LEN:      taps_len      <= pwdata[8:0];
        REG_PREAMP_GAIN:   preamp_gain   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNEL_COUNT: prdata = 32'(channel_count);
      REG_TAPS_LEN:      prdata = 32'(taps_len);
      REG_PREAMP_GAIN:   prdata = 32'(preamp_gain);
      default:           prdata = '0;
    endcase
  end

  mcfir_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .status  (status),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  mcfir_back u_back (
    .clk           (clk),
    .rst           (rst),
    .channel_count (channel_count),
    .taps_len      (taps_len),
    .preamp_gain   (preamp_gain),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .status        (status),
    .res_valid     (res_valid),
    .res_pop       (pop),
    .res_channel   (channel),
    .res_filtered  (filtered),
    .res_saturated (saturated),
    .res_frame_end (frame_end)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> full)
    else $error("input taken during history clear");

  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> empty)
    else $error("result shown during history clear");

  a_clear_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> status.clearing)
    else $error("history clear did not start after reset");

  a_pop_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && !status.busy))
    else $error("queue transfer while execution side busy");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multichannel_fir_with_gain. Gain-only, short and
// full-length filters are driven through the queue input with random gaps
// in most phases. Every result is compared against a cycle-free software
// predictor of the filter, gain and saturation path.
// ----------------------------------------------------------------------------
module testbench;
  import mcfir_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] operation = OP_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [CH_W-1:0] load_channel = '0;
  logic [7:0] tap_index = '0;
  logic signed [SAMPLE_W-1:0] coefficient = '0;
  logic [GAIN_W-1:0] gain = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CH_W-1:0] channel;
  logic signed [SAMPLE_W-1:0] filtered;
  logic saturated;
  logic frame_end;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multichannel_fir_with_gain uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .sample(sample), .load_channel(load_channel), .tap_index(tap_index),
    .coefficient(coefficient), .gain(gain), .empty(empty), .pop(pop),
    .channel(channel), .filtered(filtered), .saturated(saturated),
    .frame_end(frame_end), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  typedef struct {
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] value;
    logic                       clipped;
    logic                       last;
  } filtered_out_t;

  filtered_out_t pending_outputs[$];

  // predictor state
  int cfg_channels, cfg_taps, cfg_preamp;
  int history[MAX_CHANNELS][MAX_TAPS];
  int coeffs[MAX_CHANNELS][MAX_TAPS];
  bit coeff_loaded[MAX_CHANNELS][MAX_TAPS];
  int ch_gain[MAX_CHANNELS];
  int hist_pos, chan_pos;

  int mismatches = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int clipped_seen = 0;
  longint cycles = 0;
  bit send_gaps = 1'b1;
  bit pop_gaps = 1'b1;
  int hold_left = 0;

  function automatic int eff_channels();
    if (cfg_channels == 0) return 1;
    if (cfg_channels > MAX_CHANNELS) return MAX_CHANNELS;
    return cfg_channels;
  endfunction

  function automatic int eff_taps();
    return (cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps;
  endfunction

  function automatic longint round_q(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic void predict_fir(logic [1:0] op, logic signed [SAMPLE_W-1:0] smp,
                                      logic [CH_W-1:0] lch, logic [7:0] tidx,
                                      logic signed [SAMPLE_W-1:0] coef,
                                      logic [GAIN_W-1:0] gn);
    int cnt, t, ch, idx;
    bit last;
    longint acc, v;
    filtered_out_t e;
    case (op)
      OP_LOAD_TAP: begin
        coeffs[lch][tidx] = coef;
        coeff_loaded[lch][tidx] = 1'b1;
      end
      OP_LOAD_GAIN: ch_gain[lch] = gn;
      OP_SAMPLE: begin
        cnt = eff_channels();
        t = eff_taps();
        if (chan_pos >= cnt) chan_pos = 0;
        ch = chan_pos;
        last = (ch + 1 == cnt);
        if (t == 0) begin
          v = smp;
        end else begin
          if (hist_pos >= t) hist_pos = 0;
          history[ch][hist_pos] = smp;
          acc = 0;
          idx = hist_pos + 1;
          for (int k = 0; k < t; k++) begin
            if (idx >= t) idx = 0;
            acc += longint'(coeffs[ch][k]) * longint'(history[ch][idx]);
            idx++;
          end
          v = round_q(acc, 23);
        end
        v = round_q(v * longint'(cfg_preamp), 12);
        v = round_q(v * longint'(ch_gain[ch]), 12);
        e.clipped = 1'b0;
        if (v > 64'sd8388607) begin
          v = 8388607;
          e.clipped = 1'b1;
        end else if (v < -64'sd8388608) begin
          v = -8388608;
          e.clipped = 1'b1;
        end
        e.ch = ch[CH_W-1:0];
        e.value = v[SAMPLE_W-1:0];
        e.last = last;
        pending_outputs.push_back(e);
        if (last) begin
          chan_pos = 0;
          if (t != 0) begin
            hist_pos++;
            if (hist_pos >= t) hist_pos = 0;
          end
        end else begin
          chan_pos = ch + 1;
        end
      end
      default: ;
    endcase
  endfunction

  // Leaves push high so that back-to-back items need no extra edge.
  task automatic send_item(logic [1:0] op, logic signed [SAMPLE_W-1:0] smp,
                           logic [CH_W-1:0] lch, logic [7:0] tidx,
                           logic signed [SAMPLE_W-1:0] coef, logic [GAIN_W-1:0] gn);
    int gap;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= op;
    sample <= smp;
    load_channel <= lch;
    tap_index <= tidx;
    coefficient <= coef;
    gain <= gn;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predict_fir(op, smp, lch, tidx, coef, gn);
    if (op == OP_SAMPLE) samples_sent++;
  endtask

  task automatic send_random_item();
    int r;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < 80) op = OP_SAMPLE;
    else if (r < 90) op = OP_LOAD_TAP;
    else if (r < 97) op = OP_LOAD_GAIN;
    else op = OP_NONE;
    send_item(op, SAMPLE_W'($urandom), CH_W'($urandom), 8'($urandom),
              SAMPLE_W'($urandom), GAIN_W'($urandom));
  endtask

  // Hold the input idle until every result is back, then let the block settle.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT: cfg_channels = value & 'hF;
      REG_TAPS_LEN:      cfg_taps = value & 'h1FF;
      REG_PREAMP_GAIN:   cfg_preamp = value & 'hFFFF;
      default: ;
    endcase
  endtask

  task automatic configure(int cnt, int taps, int preamp);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, cnt);
    write_reg(REG_TAPS_LEN, taps);
    write_reg(REG_PREAMP_GAIN, preamp);
  endtask

  // Load every tap that the current setting will read and that is still unset.
  task automatic load_missing_taps(int max_mag);
    for (int c = 0; c < eff_channels(); c++)
      for (int k = 0; k < eff_taps(); k++)
        if (!coeff_loaded[c][k])
          send_item(OP_LOAD_TAP, SAMPLE_W'($urandom), CH_W'(c), 8'(k),
                    SAMPLE_W'($signed($urandom_range(0, 2 * max_mag)) - max_mag),
                    GAIN_W'($urandom));
  endtask

  task automatic test_gain_only();
    // reset setting: two channels, passthrough, unity preamp
    send_item(OP_SAMPLE, 24'sh7FFFFF, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 24'sh800000, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 24'sh000000, 7, 255, 24'sh7FFFFF, 16'hFFFF);
    send_item(OP_SAMPLE, 24'shFFFFFF, 0, 0, 0, 0);
    send_item(OP_NONE, 24'sh123456, 3, 9, 24'sh000001, 16'h0001);
    send_item(OP_LOAD_GAIN, 0, 1, 0, 0, 16'hFFFF);
    send_item(OP_LOAD_GAIN, 0, 0, 0, 0, 16'h0000);
    send_item(OP_SAMPLE, 24'sh400000, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 24'sh400000, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 24'shC00000, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 24'sh000001, 0, 0, 0, 0);
    send_item(OP_LOAD_GAIN, 0, 0, 0, 0, UNITY_GAIN);
    send_item(OP_LOAD_GAIN, 0, 1, 0, 0, UNITY_GAIN);
    configure(15, 0, 65535);
    for (int i = 0; i < 10; i++) send_item(OP_SAMPLE, SAMPLE_W'($urandom), 0, 0, 0, 0);
    configure(1, 0, 0);
    send_item(OP_SAMPLE, 24'sh7FFFFF, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 24'sh800000, 0, 0, 0, 0);
  endtask

  task automatic test_short_filters();
    int cnt, taps;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin cnt = 8; taps = 1; end
        1: begin cnt = 1; taps = 8; end
        2: begin cnt = 0; taps = 3; end
        default: begin
          cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
          taps = $urandom_range(1, 8);
        end
      endcase
      send_gaps = (ph % 4 != 3);
      pop_gaps = (ph % 4 != 3);
      configure(cnt, taps, (ph == 1) ? 65535 : $urandom_range(0, 65535));
      load_missing_taps(8388608 - 1);
      for (int i = 0; i < 45; i++) send_random_item();
    end
    send_gaps = 1'b1;
    pop_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    configure(4, 5, UNITY_GAIN);
    load_missing_taps(4000000);
    hold_left = 800;
    for (int i = 0; i < 60; i++) send_random_item();
    wait_idle();
    for (int i = 0; i < 30; i++) send_random_item();
  endtask

  task automatic test_long_filter();
    // taps_len beyond capacity is treated as the full length
    configure(1, 256, UNITY_GAIN);
    load_missing_taps(1 << 16);
    for (int i = 0; i < 6; i++) send_item(OP_SAMPLE, SAMPLE_W'($urandom), 0, 0, 0, 0);
    configure(0, 511, 65535);
    for (int i = 0; i < 6; i++) send_item(OP_SAMPLE, SAMPLE_W'($urandom), 0, 0, 0, 0);
  endtask

  // result side: random gaps, plus a long hold counted below
  initial begin
    int gap;
    bit taken;
    filtered_out_t e;
    gap = 0;
    forever begin
      @(posedge clk);
      taken = pop && !empty && !rst;
      if (taken) begin
        results_seen++;
        if (pending_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result ch=%0d value=%0d", channel, filtered);
        end else begin
          e = pending_outputs.pop_front();
          if (saturated) clipped_seen++;
          if (channel !== e.ch || filtered !== e.value || saturated !== e.clipped ||
              frame_end !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ch=%0d val=%0d sat=%0b end=%0b, got ch=%0d val=%0d sat=%0b end=%0b",
                       e.ch, e.value, e.clipped, e.last, channel, filtered, saturated, frame_end);
          end
        end
        gap = pop_gaps ? $urandom_range(0, 4) : 0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    cfg_channels = 2;
    cfg_taps = 0;
    cfg_preamp = UNITY_GAIN;
    hist_pos = 0;
    chan_pos = 0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      ch_gain[c] = UNITY_GAIN;
      for (int k = 0; k < MAX_TAPS; k++) begin
        history[c][k] = 0;
        coeffs[c][k] = 0;
        coeff_loaded[c][k] = 1'b0;
      end
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // hold off until the history clear is done
    do @(posedge clk); while (full);
    test_gain_only();
    test_short_filters();
    test_backpressure();
    test_long_filter();
    wait_idle();
    if (pending_outputs.size() != 0) mismatches++;
    $display("covered %0d samples, %0d results (%0d clipped) over gain-only, short and",
             samples_sent, results_seen, clipped_seen);
    $display("full-length filters with output hold-off; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
src/mcfir_pkg.sv
src/mcfir_ram.sv
src/mcfir_front.sv
src/mcfir_back.sv
src/multichannel_fir_with_gain.sv
tb/testbench.sv
